// ===== rtl/command_issue_timeout_abort_core_macros.svh =====
// Assertion macros for the command issue core.
// Used by command_issue_timeout_abort_core; no other dependencies.
`ifndef COMMAND_ISSUE_TIMEOUT_ABORT_CORE_MACROS_SVH
`define COMMAND_ISSUE_TIMEOUT_ABORT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define CITA_ASSERT_IMPLY(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define CITA_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CITA_ASSERT_IMPLY(name, ck, rn, ante, cons)
`define CITA_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/cita_pkg.sv =====
// Types, codes and constants of the command issue core.
// No dependencies.
package cita_pkg;

  localparam int TIME_BITS = 16;
  localparam int CFG_W     = 16;
  localparam int CMP_W     = 33;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [CFG_W-1:0] DEADLINE_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] ABORT_WIN_RST = 16'd100;

  typedef enum logic [0:0] {
    CFG_DEADLINE  = 1'b0,
    CFG_ABORT_WIN = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_START        = 2'd0,
    CMD_TICK         = 2'd1,
    CMD_SUBMIT_REPLY = 2'd2,
    CMD_POLL_REPLY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SUBMIT = 2'd1,
    ACT_POLL   = 2'd2,
    ACT_ABORT  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RES_OK              = 3'd0,
    RES_FAILED          = 3'd1,
    RES_TIMEOUT         = 3'd2,
    RES_CANCELLED       = 3'd3,
    RES_RECOVERY_FAILED = 3'd4,
    RES_INVALID         = 3'd5
  } result_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SUBMIT = 4'b0010,
    PH_POLL   = 4'b0100,
    PH_ABORT  = 4'b1000
  } phase_t;

  // Poll reply status codes
  localparam logic signed [3:0] STS_STOPPED = 4'sd0;
  localparam logic signed [3:0] STS_RUNNING = 4'sd1;
  localparam logic signed [3:0] STS_DONE    = 4'sd2;
  localparam logic signed [3:0] STS_QUEUED  = 4'sd4;
  localparam logic signed [3:0] STS_ERROR   = -4'sd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        command_code;
    logic signed [15:0] reply_handle;
    logic signed [3:0]  reply_status;
    logic               cancel;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] action_command;
    logic [14:0] action_handle;
    logic        done_res;
    logic [2:0]  result;
  } out_item_t;

endpackage

// ===== rtl/command_issue_timeout_abort_core.sv =====
// A transfer passes the input register and then the result register on its way to out_data.
// Throughput: one item per cycle; input register and result register each take a
// transfer in every cycle that the result side does not stall.
// Reset (rst_n low, synchronous): both channels empty, phase idle, counters and handle
// cleared, deadline 1000 ms and abort window 100 ms.
// Depends on cita_pkg and command_issue_timeout_abort_core_macros.svh.
`include "command_issue_timeout_abort_core_macros.svh"

module command_issue_timeout_abort_core
  import cita_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration write port
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers, read live at each decision
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] deadline_r;
  logic [CFG_W-1:0] abort_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r  <= DEADLINE_RST;
      abort_win_r <= ABORT_WIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEADLINE:  deadline_r  <= cfg_data;
        CFG_ABORT_WIN: abort_win_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register
  // ---------------------------------------------------------------------------
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      s1_fire;
  logic      in_load;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  // Hold the input register only while it is full and cannot advance.
  assign in_stall = s1_valid_r && !out_free;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Command state
  // ---------------------------------------------------------------------------
  phase_t                phase_r,         phase_nxt;
  logic [TIME_BITS-1:0]  elapsed_r,       elapsed_nxt;
  logic [TIME_BITS-1:0]  abort_elapsed_r, abort_elapsed_nxt;
  logic [14:0]           live_handle_r,   live_handle_nxt;
  logic [15:0]           held_cmd_r,      held_cmd_nxt;
  result_t               pending_r,       pending_nxt;

  // decision outcome of the current item
  action_t   act;
  logic      done;
  result_t   res;
  out_item_t out_nxt;
  logic      expired;
  logic      abort_open;
  logic      exec_fall;

  // Timer compares at a common width so the counter width may differ from the config width.
  assign expired    = CMP_W'(elapsed_r) >= CMP_W'(deadline_r);
  assign abort_open = CMP_W'(abort_elapsed_r) < CMP_W'(abort_win_r);

  always_comb begin
    phase_nxt         = phase_r;
    elapsed_nxt       = elapsed_r;
    abort_elapsed_nxt = abort_elapsed_r;
    live_handle_nxt   = live_handle_r;
    held_cmd_nxt      = held_cmd_r;
    pending_nxt       = pending_r;
    act               = ACT_NONE;
    done              = 1'b0;
    res               = RES_OK;
    exec_fall         = 1'b0;

    case (cmd_t'(s1_data_r.cmd))
      CMD_START: begin
        if (phase_r != PH_IDLE) begin
          // drop: start while a command is live
        end else if (deadline_r == '0 || abort_win_r == '0) begin
          done = 1'b1;
          res  = RES_INVALID;
        end else begin
          held_cmd_nxt      = s1_data_r.command_code;
          live_handle_nxt   = '0;
          elapsed_nxt       = '0;
          abort_elapsed_nxt = '0;
          pending_nxt       = RES_OK;
          // Fresh deadline is nonzero, so only cancel can end here.
          if (s1_data_r.cancel) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            res       = RES_CANCELLED;
          end else begin
            phase_nxt = PH_SUBMIT;
            act       = ACT_SUBMIT;
          end
        end
      end

      CMD_TICK: begin
        if (phase_r != PH_IDLE && elapsed_r != TIME_MAX) begin
          elapsed_nxt = TIME_BITS'(elapsed_r + 1'b1);
        end
        if (phase_r == PH_ABORT && abort_elapsed_r != TIME_MAX) begin
          abort_elapsed_nxt = TIME_BITS'(abort_elapsed_r + 1'b1);
        end
      end

      CMD_SUBMIT_REPLY: begin
        if (phase_r != PH_SUBMIT) begin
          // drop stray submit reply
        end else if (s1_data_r.reply_handle < 0) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          res       = RES_FAILED;
        end else if (s1_data_r.reply_handle == 0) begin
          // Busy: retry, or end without abort since nothing is live yet.
          if (s1_data_r.cancel) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            res       = RES_CANCELLED;
          end else if (expired) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            res       = RES_TIMEOUT;
          end else begin
            act = ACT_SUBMIT;
          end
        end else begin
          live_handle_nxt = s1_data_r.reply_handle[14:0];
          exec_fall       = 1'b1;
        end
      end

      CMD_POLL_REPLY: begin
        unique case (phase_r)
          PH_POLL: begin
            if (s1_data_r.reply_status == STS_DONE) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              res       = RES_OK;
            end else if (s1_data_r.reply_status == STS_STOPPED ||
                         s1_data_r.reply_status == STS_ERROR) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              res       = RES_FAILED;
            end else if (s1_data_r.reply_status == STS_RUNNING ||
                         s1_data_r.reply_status == STS_QUEUED) begin
              exec_fall = 1'b1;
            end else begin
              // unexpected status: abort and report failure once settled
              pending_nxt       = RES_FAILED;
              abort_elapsed_nxt = '0;
              phase_nxt         = PH_ABORT;
              act               = ACT_ABORT;
            end
          end
          PH_ABORT: begin
            if (s1_data_r.reply_status == STS_STOPPED ||
                s1_data_r.reply_status == STS_DONE ||
                s1_data_r.reply_status == STS_ERROR) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              res       = pending_r;
            end else if (abort_open) begin
              act = ACT_POLL;
            end else begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              res       = RES_RECOVERY_FAILED;
            end
          end
          PH_IDLE, PH_SUBMIT: begin
            // drop stray poll reply
          end
          default: ;
        endcase
      end

      default: ;
    endcase

    // Execution decision point after acceptance.
    if (exec_fall) begin
      if (s1_data_r.cancel) begin
        pending_nxt       = RES_CANCELLED;
        abort_elapsed_nxt = '0;
        phase_nxt         = PH_ABORT;
        act               = ACT_ABORT;
      end else if (expired) begin
        pending_nxt       = RES_TIMEOUT;
        abort_elapsed_nxt = '0;
        phase_nxt         = PH_ABORT;
        act               = ACT_ABORT;
      end else begin
        phase_nxt = PH_POLL;
        act       = ACT_POLL;
      end
    end

    out_nxt.action         = act;
    out_nxt.action_command = (act == ACT_SUBMIT) ? held_cmd_nxt : '0;
    out_nxt.action_handle  = (act == ACT_POLL || act == ACT_ABORT) ? live_handle_nxt : '0;
    out_nxt.done_res       = done;
    out_nxt.result         = done ? res : RES_OK;
  end

  // Advance the command state only when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      elapsed_r       <= '0;
      abort_elapsed_r <= '0;
      live_handle_r   <= '0;
      held_cmd_r      <= '0;
      pending_r       <= RES_OK;
    end else if (s1_fire) begin
      phase_r         <= phase_nxt;
      elapsed_r       <= elapsed_nxt;
      abort_elapsed_r <= abort_elapsed_nxt;
      live_handle_r   <= live_handle_nxt;
      held_cmd_r      <= held_cmd_nxt;
      pending_r       <= pending_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An abort always targets a handle the partner accepted.
  `CITA_ASSERT_IMPLY(a_abort_has_handle, clk, rst_n, phase_r == PH_ABORT, live_handle_r != '0)
  // No handle is held while submission is still in progress.
  `CITA_ASSERT_IMPLY(a_submit_no_handle, clk, rst_n, phase_r == PH_SUBMIT, live_handle_r == '0)
  // Idle phase leaves only through a processed item.
  `CITA_ASSERT_NEXT(a_idle_holds, clk, rst_n, phase_r == PH_IDLE && !s1_fire, phase_r == PH_IDLE)

endmodule
